[rtl/rcsg_pkg.sv]
// Shared types, constants and helpers for the rotary cos/sin generator.
`timescale 1ns / 1ps
package rcsg_pkg;

  // Parameter defaults
  localparam int MAX_PAIRS_DEF    = 64;
  localparam int POS_BITS_DEF     = 16;
  localparam int CORDIC_STEPS_DEF = 18;

  // Fixed field and datapath widths
  localparam int FREQ_W     = 40;  // running frequency, Q0.40 turns
  localparam int PHASE_W    = 32;  // CORDIC angle, 2^32 = one turn
  localparam int XY_W       = 34;  // CORDIC x/y, Q2.30 with headroom
  localparam int Z_W        = 33;  // CORDIC residual angle
  localparam int PAIR_W     = 6;
  localparam int VAL_W      = 16;
  localparam int THETA_W    = 32;
  localparam int HP_W       = 7;
  localparam int MAXPOS_W   = 17;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int ATAN_DEPTH = 30;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FREQ_RATIO    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_PAIRS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_POSITIONS = 2'd2;

  // Register reset values
  localparam logic [THETA_W-1:0]  FREQ_RATIO_RST    = 32'd3719273000;
  localparam logic [HP_W-1:0]     HALF_PAIRS_RST    = 7'd64;
  localparam logic [MAXPOS_W-1:0] MAX_POSITIONS_RST = 17'd4096;

  // round(2^40 / (2*pi)) and inverse CORDIC gain in Q2.30
  localparam logic [FREQ_W-1:0]      START_FREQ  = 40'd174992710548;
  localparam logic signed [XY_W-1:0] CORDIC_GAIN = 34'sd652032874;

  // Truncated arctangent of 2^-k in turns, 2^32 = one turn
  localparam logic [PHASE_W-1:0] ARCTAN [ATAN_DEPTH] = '{
    32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
    32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001
  };

  // Per-beat control that travels down the pipeline
  typedef struct packed {
    logic              valid;
    logic              oor;
    logic              last;
    logic [PAIR_W-1:0] pair_index;
  } ctl_t;

  // Contents of one CORDIC cell register
  typedef struct packed {
    ctl_t                    ctl;
    logic [1:0]              quad;
    logic signed [XY_W-1:0]  x;
    logic signed [XY_W-1:0]  y;
    logic signed [Z_W-1:0]   z;
  } cell_t;

  // Q2.30 to Q1.15: add half, floor shift, saturate
  function automatic logic signed [VAL_W-1:0] to_q15(input logic signed [XY_W-1:0] v);
    logic signed [XY_W:0]    t;
    logic signed [XY_W-15:0] r;
    t = (XY_W+1)'(v) + $signed((XY_W+1)'(16384));
    r = $signed(t[XY_W:15]);
    if (r > $signed((XY_W-14)'(32767))) begin
      return 16'sh7FFF;
    end else if (r < $signed((XY_W-14)'(-32768))) begin
      return 16'sh8000;
    end else begin
      return r[VAL_W-1:0];
    end
  endfunction

endpackage

[rtl/rcsg_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module rcsg_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/rcsg_freq_fill.sv]
// Fills the frequency table with START_FREQ * (freq_ratio / 2^32)^i, writing in F_LO and stepping in F_HI.
`timescale 1ns / 1ps
module rcsg_freq_fill #(
  parameter int MAX_PAIRS = rcsg_pkg::MAX_PAIRS_DEF,
  localparam int IDX_W = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        restart,
  input  logic [rcsg_pkg::THETA_W-1:0] freq_ratio,
  output logic                        filling,
  output logic                        wr_en,
  output logic [IDX_W-1:0]            wr_addr,
  output logic [rcsg_pkg::FREQ_W-1:0] wr_data
);

  localparam int HALF_W = rcsg_pkg::THETA_W / 2;
  localparam int LO_W   = rcsg_pkg::FREQ_W + HALF_W;

  typedef enum logic [1:0] {F_LO, F_HI, F_DONE} fill_state_t;

  fill_state_t                 state;
  logic [IDX_W-1:0]            addr;
  logic [rcsg_pkg::FREQ_W-1:0] freq;
  logic [LO_W-1:0]             lo;
  logic [LO_W-1:0]             lo_next;
  logic [LO_W:0]               mid_next;

  // Split 40x32 product into two 40x16 halves
  assign lo_next  = LO_W'(freq) * LO_W'(freq_ratio[HALF_W-1:0]);
  assign mid_next = (LO_W+1)'(LO_W'(freq) * LO_W'(freq_ratio[rcsg_pkg::THETA_W-1:HALF_W]))
                  + (LO_W+1)'(lo[LO_W-1:HALF_W]);

  // Step through the table: write entry, then form the next frequency
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      state <= F_LO;
      addr  <= '0;
      freq  <= rcsg_pkg::START_FREQ;
      lo    <= '0;
    end else begin
      unique case (state)
        F_LO: begin
          lo    <= lo_next;
          state <= F_HI;
        end
        F_HI: begin
          freq <= mid_next[HALF_W +: rcsg_pkg::FREQ_W];
          if (addr == IDX_W'(MAX_PAIRS - 1)) begin
            state <= F_DONE;
          end else begin
            addr  <= IDX_W'(addr + 1'b1);
            state <= F_LO;
          end
        end
        F_DONE: begin
          state <= F_DONE;
        end
        default: begin
          state <= F_DONE;
        end
      endcase
    end
  end

  assign filling = (state != F_DONE);
  assign wr_en   = (state == F_LO);
  assign wr_addr = addr;
  assign wr_data = freq;

  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    (state == F_DONE && !restart) |=> (state == F_DONE))
    else $error("fill sequencer left done without a restart");

  a_restart_refills: assert property (@(posedge clk) disable iff (rst)
    restart |=> (state == F_LO && addr == '0 && freq == rcsg_pkg::START_FREQ))
    else $error("fill did not restart from the first entry");

endmodule

[rtl/rcsg_cordic_cell.sv]
// One CORDIC rotation step, registered, handing its vector to the next cell.
`timescale 1ns / 1ps
module rcsg_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            adv,
  input  rcsg_pkg::cell_t cin,
  output rcsg_pkg::cell_t cout
);

  logic signed [rcsg_pkg::XY_W-1:0] dx;
  logic signed [rcsg_pkg::XY_W-1:0] dy;
  logic signed [rcsg_pkg::Z_W-1:0]  atan;
  rcsg_pkg::cell_t                  cnext;

  assign dx   = cin.y >>> STEP;
  assign dy   = cin.x >>> STEP;
  assign atan = $signed({1'b0, rcsg_pkg::ARCTAN[STEP]});

  // Rotate toward zero residual angle
  always_comb begin
    cnext = cin;
    if (!cin.z[rcsg_pkg::Z_W-1]) begin
      cnext.x = cin.x - dx;
      cnext.y = cin.y + dy;
      cnext.z = cin.z - atan;
    end else begin
      cnext.x = cin.x + dx;
      cnext.y = cin.y - dy;
      cnext.z = cin.z + atan;
    end
  end

  // Hold while the pipeline is stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      cout <= '0;
    end else if (adv) begin
      cout <= cnext;
    end
  end

endmodule

[rtl/rope_cos_sin_generator_core.sv]
// Top level: position sequencer, frequency table, phase multiply, CORDIC cell chain.
// Beats pass stage 1 (frequency read), stage 2, the fold register, the CORDIC cells and
// the output register, all held while the output stalls. Throughput: one result beat per
// cycle when not stalled, so a position holds the issue slot for min(max(half_pairs,1),
// MAX_PAIRS) beats (one if out of range). The next position is taken in the cycle its
// predecessor issues its last pair. Reset (and every freq_ratio write) refills the table
// with pos_stall high. Registers reset to 3719273000 / 64 / 4096, pipeline resets empty.
`timescale 1ns / 1ps
module rope_cos_sin_generator_core #(
  parameter int MAX_PAIRS    = rcsg_pkg::MAX_PAIRS_DEF,
  parameter int POS_BITS     = rcsg_pkg::POS_BITS_DEF,
  parameter int CORDIC_STEPS = rcsg_pkg::CORDIC_STEPS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // configuration
  input  logic                              wr_en,
  input  logic [rcsg_pkg::CFG_IDX_W-1:0]    wr_index,
  input  logic [rcsg_pkg::CFG_DATA_W-1:0]   wr_data,
  // position channel
  input  logic                              pos_valid,
  output logic                              pos_stall,
  input  logic [POS_BITS-1:0]               position,
  // result channel
  output logic                              res_valid,
  input  logic                              res_stall,
  output logic [rcsg_pkg::PAIR_W-1:0]       pair_index,
  output logic signed [rcsg_pkg::VAL_W-1:0] cos_value,
  output logic signed [rcsg_pkg::VAL_W-1:0] sin_value,
  output logic                              last,
  output logic                              out_of_range
);

  localparam int IDX_W = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
  localparam int CMP_W = (POS_BITS > rcsg_pkg::MAXPOS_W) ? POS_BITS : rcsg_pkg::MAXPOS_W;
  localparam int HPX_W = 9;

  // Configuration registers
  logic [rcsg_pkg::THETA_W-1:0]  freq_ratio;
  logic [rcsg_pkg::HP_W-1:0]     half_pairs;
  logic [rcsg_pkg::MAXPOS_W-1:0] max_positions;
  logic                          theta_wr;

  assign theta_wr = wr_en && (wr_index == rcsg_pkg::REG_FREQ_RATIO);

  always_ff @(posedge clk) begin
    if (rst) begin
      freq_ratio    <= rcsg_pkg::FREQ_RATIO_RST;
      half_pairs    <= rcsg_pkg::HALF_PAIRS_RST;
      max_positions <= rcsg_pkg::MAX_POSITIONS_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        rcsg_pkg::REG_FREQ_RATIO:    freq_ratio    <= wr_data[rcsg_pkg::THETA_W-1:0];
        rcsg_pkg::REG_HALF_PAIRS:    half_pairs    <= wr_data[rcsg_pkg::HP_W-1:0];
        rcsg_pkg::REG_MAX_POSITIONS: max_positions <= wr_data[rcsg_pkg::MAXPOS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Frequency table fill and storage
  logic                        filling;
  logic                        tab_we;
  logic [IDX_W-1:0]            tab_waddr;
  logic [rcsg_pkg::FREQ_W-1:0] tab_wdata;
  logic [rcsg_pkg::FREQ_W-1:0] freq_rd;
  logic                        adv;
  logic [IDX_W-1:0]            pair_cnt;

  rcsg_freq_fill #(
    .MAX_PAIRS (MAX_PAIRS)
  ) u_fill (
    .clk        (clk),
    .rst        (rst),
    .restart    (theta_wr),
    .freq_ratio (freq_ratio),
    .filling    (filling),
    .wr_en      (tab_we),
    .wr_addr    (tab_waddr),
    .wr_data    (tab_wdata)
  );

  rcsg_ram #(
    .WIDTH (rcsg_pkg::FREQ_W),
    .DEPTH (MAX_PAIRS)
  ) u_freq_ram (
    .clk   (clk),
    .we    (tab_we),
    .waddr (tab_waddr),
    .wdata (tab_wdata),
    .re    (adv),
    .raddr (pair_cnt),
    .rdata (freq_rd)
  );

  // Pipeline advances whenever the output register can take a beat
  assign adv = !res_valid || !res_stall;

  // Issue sequencer: one pair per advancing cycle
  logic                 busy;
  logic [IDX_W-1:0]     last_idx;
  logic [POS_BITS-1:0]  cur_pos;
  logic                 cur_oor;
  logic                 issue_last;
  logic                 take;
  logic                 new_oor;
  logic [HPX_W-1:0]     hp_ext;
  logic [IDX_W-1:0]     new_last_idx;

  assign issue_last = (pair_cnt == last_idx);
  assign pos_stall  = filling || (busy && !(adv && issue_last));
  assign take       = pos_valid && !pos_stall;
  assign new_oor    = CMP_W'(position) >= CMP_W'(max_positions);
  assign hp_ext     = HPX_W'(half_pairs);

  // Clamp pair count to [1, MAX_PAIRS]; out of range gives one beat
  always_comb begin
    if (new_oor || hp_ext == '0) begin
      new_last_idx = '0;
    end else if (hp_ext > HPX_W'(MAX_PAIRS)) begin
      new_last_idx = IDX_W'(MAX_PAIRS - 1);
    end else begin
      new_last_idx = IDX_W'(hp_ext - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      pair_cnt <= '0;
    end else if (take) begin
      busy     <= 1'b1;
      pair_cnt <= '0;
    end else if (busy && adv) begin
      if (issue_last) begin
        busy <= 1'b0;
      end else begin
        pair_cnt <= IDX_W'(pair_cnt + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cur_pos  <= position;
      cur_oor  <= new_oor;
      last_idx <= new_last_idx;
    end
  end

  // Stage 1: frequency read, beat control and position
  rcsg_pkg::ctl_t      s1_ctl;
  logic [POS_BITS-1:0] s1_pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctl <= '0;
      s1_pos <= '0;
    end else if (adv) begin
      s1_ctl.valid      <= busy;
      s1_ctl.oor        <= cur_oor;
      s1_ctl.last       <= issue_last;
      s1_ctl.pair_index <= rcsg_pkg::PAIR_W'(pair_cnt);
      s1_pos            <= cur_pos;
    end
  end

  // Stage 2: phase = position * frequency mod one turn
  rcsg_pkg::ctl_t               s2_ctl;
  logic [rcsg_pkg::PHASE_W-1:0] s2_phase;
  logic [rcsg_pkg::FREQ_W-1:0]  phase40;

  assign phase40 = rcsg_pkg::FREQ_W'(s1_pos) * freq_rd;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_ctl   <= '0;
      s2_phase <= '0;
    end else if (adv) begin
      s2_ctl   <= s1_ctl;
      s2_phase <= phase40[rcsg_pkg::FREQ_W-1 -: rcsg_pkg::PHASE_W];
    end
  end

  // Stage 3: fold the quadrant so the residual lies in [-1/8, 1/8) turn
  rcsg_pkg::cell_t stage [CORDIC_STEPS+1];
  rcsg_pkg::cell_t fold;

  always_comb begin
    fold.ctl  = s2_ctl;
    fold.quad = 2'(s2_phase[31:30] + s2_phase[29]);
    fold.x    = rcsg_pkg::CORDIC_GAIN;
    fold.y    = '0;
    fold.z    = rcsg_pkg::Z_W'($signed(s2_phase[29:0]));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage[0] <= '0;
    end else if (adv) begin
      stage[0] <= fold;
    end
  end

  // CORDIC cell chain
  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cell
    rcsg_cordic_cell #(
      .STEP (k)
    ) u_cell (
      .clk  (clk),
      .rst  (rst),
      .adv  (adv),
      .cin  (stage[k]),
      .cout (stage[k+1])
    );
  end

  // Quadrant rotate and convert to Q1.15
  rcsg_pkg::cell_t                  tail;
  logic signed [rcsg_pkg::XY_W-1:0] c_full;
  logic signed [rcsg_pkg::XY_W-1:0] s_full;

  assign tail = stage[CORDIC_STEPS];

  always_comb begin
    unique case (tail.quad)
      2'd0: begin c_full = tail.x;  s_full = tail.y;  end
      2'd1: begin c_full = -tail.y; s_full = tail.x;  end
      2'd2: begin c_full = -tail.x; s_full = -tail.y; end
      2'd3: begin c_full = tail.y;  s_full = -tail.x; end
      default: begin c_full = tail.x; s_full = tail.y; end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid    <= 1'b0;
      pair_index   <= '0;
      cos_value    <= '0;
      sin_value    <= '0;
      last         <= 1'b0;
      out_of_range <= 1'b0;
    end else if (adv) begin
      res_valid    <= tail.ctl.valid;
      pair_index   <= tail.ctl.pair_index;
      last         <= tail.ctl.last;
      out_of_range <= tail.ctl.oor;
      if (tail.ctl.oor) begin
        cos_value <= '0;
        sin_value <= '0;
      end else begin
        cos_value <= rcsg_pkg::to_q15(c_full);
        sin_value <= rcsg_pkg::to_q15(s_full);
      end
    end
  end

  a_no_take_while_filling: assert property (@(posedge clk) disable iff (rst)
    filling |-> pos_stall)
    else $error("position taken while frequency table fills");

  a_oor_beat_shape: assert property (@(posedge clk) disable iff (rst)
    (res_valid && out_of_range) |->
      (cos_value == '0 && sin_value == '0 && last && pair_index == '0))
    else $error("out-of-range beat not a single zero beat");

  a_pair_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    busy |-> (pair_cnt <= last_idx))
    else $error("pair counter ran past the last pair");

endmodule

[tb/sv/rope_pair_checker.sv]
// Result predictor and scoreboard for the rotary cos/sin generator.
`timescale 1ns / 1ps
module rope_pair_checker #(
  parameter int MAX_PAIRS    = rcsg_pkg::MAX_PAIRS_DEF,
  parameter int POS_BITS     = rcsg_pkg::POS_BITS_DEF,
  parameter int CORDIC_STEPS = rcsg_pkg::CORDIC_STEPS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              wr_en,
  input  logic [rcsg_pkg::CFG_IDX_W-1:0]    wr_index,
  input  logic [rcsg_pkg::CFG_DATA_W-1:0]   wr_data,
  input  logic                              pos_valid,
  input  logic                              pos_stall,
  input  logic [POS_BITS-1:0]               position,
  input  logic                              res_valid,
  input  logic                              res_stall,
  input  logic [rcsg_pkg::PAIR_W-1:0]       pair_index,
  input  logic signed [rcsg_pkg::VAL_W-1:0] cos_value,
  input  logic signed [rcsg_pkg::VAL_W-1:0] sin_value,
  input  logic                              last,
  input  logic                              out_of_range,
  output int                                errors,
  output int                                outstanding
);

  localparam longint EIGHTH_TURN  = 64'sh20000000;
  localparam longint QUARTER_TURN = 64'sh40000000;

  typedef struct packed {
    logic [rcsg_pkg::PAIR_W-1:0]       pair_index;
    logic signed [rcsg_pkg::VAL_W-1:0] cos_value;
    logic signed [rcsg_pkg::VAL_W-1:0] sin_value;
    logic                              last;
    logic                              oor;
  } pair_beat_t;

  pair_beat_t pair_q[$];

  logic [rcsg_pkg::THETA_W-1:0]  freq_ratio;
  logic [rcsg_pkg::HP_W-1:0]     half_pairs;
  logic [rcsg_pkg::MAXPOS_W-1:0] max_positions;
  int                            fail_n = 0;
  int                            pending_n = 0;

  assign errors      = fail_n;
  assign outstanding = pending_n;

  // Round Q2.30 to Q1.15 and clamp
  function automatic logic signed [rcsg_pkg::VAL_W-1:0] round_q15(input longint v);
    longint r;
    r = (v + 64'sd16384) >>> 15;
    if (r > 64'sd32767) begin
      r = 64'sd32767;
    end else if (r < -64'sd32768) begin
      r = -64'sd32768;
    end
    return 16'(r);
  endfunction

  // Fold the quadrant, rotate by the residual angle, unfold
  function automatic void rotate(input logic [rcsg_pkg::PHASE_W-1:0] angle,
                                 output logic signed [rcsg_pkg::VAL_W-1:0] c_out,
                                 output logic signed [rcsg_pkg::VAL_W-1:0] s_out);
    logic [1:0] quad;
    longint     x, y, z, dx, dy, c, s;
    quad = angle[31:30];
    z = longint'(angle[29:0]);
    x = longint'(rcsg_pkg::CORDIC_GAIN);
    y = 0;
    if (z >= EIGHTH_TURN) begin
      z = z - QUARTER_TURN;
      quad = quad + 2'd1;
    end
    for (int k = 0; k < CORDIC_STEPS && k < rcsg_pkg::ATAN_DEPTH; k++) begin
      dx = y >>> k;
      dy = x >>> k;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - longint'(rcsg_pkg::ARCTAN[k]);
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + longint'(rcsg_pkg::ARCTAN[k]);
      end
    end
    case (quad)
      2'd0: begin c = x;  s = y;  end
      2'd1: begin c = -y; s = x;  end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y;  s = -x; end
    endcase
    c_out = round_q15(c);
    s_out = round_q15(s);
  endfunction

  // Queue every cos/sin pair that one position produces
  function automatic void queue_pairs(input logic [POS_BITS-1:0] pos);
    logic [rcsg_pkg::FREQ_W-1:0]       freq;
    logic [71:0]                       prod;
    logic [63:0]                       phase;
    logic signed [rcsg_pkg::VAL_W-1:0] c, s;
    int                                count;
    pair_beat_t                        b;
    b = '0;
    if (longint'(pos) >= longint'(max_positions)) begin
      b.last = 1'b1;
      b.oor  = 1'b1;
      pair_q.push_back(b);
    end else begin
      count = int'(half_pairs);
      if (count == 0) count = 1;
      if (count > MAX_PAIRS) count = MAX_PAIRS;
      freq = rcsg_pkg::START_FREQ;
      for (int i = 0; i < count; i++) begin
        phase = 64'(pos) * 64'(freq);
        rotate(phase[39:8], c, s);
        b.pair_index = rcsg_pkg::PAIR_W'(i);
        b.cos_value  = c;
        b.sin_value  = s;
        b.last       = (i == count - 1);
        b.oor        = 1'b0;
        pair_q.push_back(b);
        prod = 72'(freq) * 72'(freq_ratio);
        freq = prod[71:32];
      end
    end
  endfunction

  // Compare result beats, predict on position beats, track register writes
  always @(posedge clk) begin
    pair_beat_t e;
    if (rst) begin
      freq_ratio    = rcsg_pkg::FREQ_RATIO_RST;
      half_pairs    = rcsg_pkg::HALF_PAIRS_RST;
      max_positions = rcsg_pkg::MAX_POSITIONS_RST;
      pair_q.delete();
    end else begin
      if (res_valid && !res_stall) begin
        if (pair_q.size() == 0) begin
          $error("result beat with nothing expected: pair_index %0d", pair_index);
          fail_n++;
        end else begin
          e = pair_q.pop_front();
          if (pair_index !== e.pair_index) begin
            $error("pair_index expected %0d got %0d", e.pair_index, pair_index);
            fail_n++;
          end
          if (cos_value !== e.cos_value) begin
            $error("cos_value expected %0d got %0d", e.cos_value, cos_value);
            fail_n++;
          end
          if (sin_value !== e.sin_value) begin
            $error("sin_value expected %0d got %0d", e.sin_value, sin_value);
            fail_n++;
          end
          if (last !== e.last) begin
            $error("last expected %0d got %0d", e.last, last);
            fail_n++;
          end
          if (out_of_range !== e.oor) begin
            $error("out_of_range expected %0d got %0d", e.oor, out_of_range);
            fail_n++;
          end
        end
      end
      if (pos_valid && !pos_stall) begin
        queue_pairs(position);
      end
      if (wr_en) begin
        case (wr_index)
          rcsg_pkg::REG_FREQ_RATIO:    freq_ratio    = wr_data[rcsg_pkg::THETA_W-1:0];
          rcsg_pkg::REG_HALF_PAIRS:    half_pairs    = wr_data[rcsg_pkg::HP_W-1:0];
          rcsg_pkg::REG_MAX_POSITIONS: max_positions = wr_data[rcsg_pkg::MAXPOS_W-1:0];
          default: ;
        endcase
      end
    end
    pending_n = pair_q.size();
  end

endmodule

[tb/sv/tb_rope_cos_sin_generator_core.sv]
// Testbench top: clock, reset, position and register stimulus, final verdict.
`timescale 1ns / 1ps
module tb_rope_cos_sin_generator_core;

  localparam int      POS_BITS       = rcsg_pkg::POS_BITS_DEF;
  localparam int      CLK_PERIOD     = 4;
  localparam int      TIMEOUT_CYCLES = 400000;
  localparam int      PHASE_ITEMS    = 40;
  localparam int      PHASES         = 9;
  localparam logic [rcsg_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              wr_en = 1'b0;
  logic [rcsg_pkg::CFG_IDX_W-1:0]    wr_index = '0;
  logic [rcsg_pkg::CFG_DATA_W-1:0]   wr_data = '0;
  logic                              pos_valid = 1'b0;
  logic                              pos_stall;
  logic [POS_BITS-1:0]               position = '0;
  logic                              res_valid;
  logic                              res_stall = 1'b0;
  logic [rcsg_pkg::PAIR_W-1:0]       pair_index;
  logic signed [rcsg_pkg::VAL_W-1:0] cos_value;
  logic signed [rcsg_pkg::VAL_W-1:0] sin_value;
  logic                              last;
  logic                              out_of_range;

  logic pos_took = 1'b0;
  logic pos_idle = 1'b1;
  logic res_idle = 1'b1;
  int   errors;
  int   outstanding;

  always #(CLK_PERIOD / 2.0) clk = ~clk;

  rope_cos_sin_generator_core i_dut (
    .clk, .rst, .wr_en, .wr_index, .wr_data,
    .pos_valid, .pos_stall, .position,
    .res_valid, .res_stall, .pair_index, .cos_value, .sin_value, .last, .out_of_range
  );

  rope_pair_checker u_check (
    .clk, .rst, .wr_en, .wr_index, .wr_data,
    .pos_valid, .pos_stall, .position,
    .res_valid, .res_stall, .pair_index, .cos_value, .sin_value, .last, .out_of_range,
    .errors, .outstanding
  );

  // Note each position beat taken
  always @(posedge clk) pos_took <= pos_valid && !pos_stall;

  // Stall the result side at random
  always @(negedge clk) res_stall <= res_idle && ($urandom_range(99) < 10);

  // Offer one position and hold it until taken
  task automatic send_pos(input logic [POS_BITS-1:0] p);
    while (pos_idle && $urandom_range(99) < 10) begin
      pos_valid = 1'b0;
      @(negedge clk);
    end
    pos_valid = 1'b1;
    position  = p;
    @(negedge clk);
    while (!pos_took) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [rcsg_pkg::CFG_IDX_W-1:0] idx,
                           input logic [rcsg_pkg::CFG_DATA_W-1:0] d);
    wr_en    = 1'b1;
    wr_index = idx;
    wr_data  = d;
    @(negedge clk);
  endtask

  // Drain, then load all registers; upper data bits carry junk to test masking
  task automatic set_config(input logic [31:0] theta, input logic [31:0] hp,
                            input logic [31:0] mp);
    pos_valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    cfg_write(REG_UNUSED, $urandom());
    cfg_write(rcsg_pkg::REG_HALF_PAIRS, ($urandom() & ~32'h7F) | (hp & 32'h7F));
    cfg_write(rcsg_pkg::REG_MAX_POSITIONS, ($urandom() & ~32'h1FFFF) | (mp & 32'h1FFFF));
    cfg_write(rcsg_pkg::REG_FREQ_RATIO, theta);
    wr_en = 1'b0;
  endtask

  // Mostly in-range positions, some anywhere in the field
  function automatic logic [POS_BITS-1:0] pick_position(input logic [31:0] mp);
    if (mp != 0 && $urandom_range(99) < 80) begin
      if (mp > 65536) return POS_BITS'($urandom());
      return POS_BITS'($urandom_range(mp - 1, 0));
    end
    return POS_BITS'($urandom());
  endfunction

  initial begin
    logic [31:0] theta, hp, mp;
    repeat (9) @(negedge clk);
    rst = 1'b0;

    // Directed: reset settings, range edges
    send_pos(0);
    send_pos(1);
    send_pos(4095);
    send_pos(4096);
    send_pos(16'hFFFF);
    // Full range, alternating bit patterns
    set_config(rcsg_pkg::FREQ_RATIO_RST, 3, 65536);
    send_pos(16'hFFFF);
    send_pos(16'h5555);
    send_pos(16'hAAAA);
    send_pos(16'h8000);
    // Zero pair count acts as one
    set_config(rcsg_pkg::FREQ_RATIO_RST, 0, 65536);
    send_pos(777);
    send_pos(16'hFFFF);
    // Pair count above the limit clips
    set_config(rcsg_pkg::FREQ_RATIO_RST, 100, 65536);
    send_pos(12345);
    set_config(rcsg_pkg::FREQ_RATIO_RST, 65, 65536);
    send_pos(1);
    // Ratio extremes
    set_config(32'h0, 4, 65536);
    send_pos(100);
    send_pos(16'hFFFF);
    set_config(32'hFFFFFFFF, 4, 65536);
    send_pos(16'hFFFF);
    send_pos(1);
    // Every position out of range
    set_config(rcsg_pkg::FREQ_RATIO_RST, 4, 0);
    send_pos(0);
    send_pos(16'hFFFF);
    // Limit beyond the position field
    set_config(rcsg_pkg::FREQ_RATIO_RST, 2, 131071);
    send_pos(16'hFFFF);
    send_pos(0);
    set_config(rcsg_pkg::FREQ_RATIO_RST, 2, 1);
    send_pos(0);
    send_pos(1);

    // Random phases over a spread of settings
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: theta = rcsg_pkg::FREQ_RATIO_RST;
        1: theta = 32'hFFFFFFFF;
        2: theta = 32'h0;
        default: theta = ($urandom_range(1) == 1) ? $urandom_range(32'hFFFFFFFF, 32'hC0000000)
                                                 : $urandom();
      endcase
      case (ph)
        3, 7: hp = 64;
        5: hp = $urandom_range(127, 65);
        6: hp = 0;
        default: hp = $urandom_range(12, 1);
      endcase
      case (ph % 3)
        0: mp = 65536;
        1: mp = $urandom_range(65536, 1);
        default: mp = $urandom_range(131071, 65537);
      endcase
      // Hold both sides busy for one whole phase
      pos_idle <= (ph != 4);
      res_idle <= (ph != 4);
      set_config(theta, hp, mp);
      repeat (PHASE_ITEMS) send_pos(pick_position(mp));
    end

    // Drain and let the pipeline settle
    pos_valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (rcsg_pkg::CORDIC_STEPS_DEF + 10) @(negedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("TEST FAILED");
    $finish;
  end

endmodule
